/* rtl/hcbd_pkg.sv */
// package for the chunked body decoder: phase and result codes, byte constants
// and character class helpers; no dependencies
package hcbd_pkg;

    localparam int unsigned DATA_W = 32;
    localparam logic [DATA_W-1:0] MAX_BODY_RESET = 32'd67108864;
    localparam int unsigned ADDR_W = 3;
    localparam logic [ADDR_W-1:0] ADDR_MAX_BODY = 3'd0;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    typedef enum logic [10:0] {
        PH_LEAD    = 11'b000_0000_0001,
        PH_DIGITS  = 11'b000_0000_0010,
        PH_TRAIL   = 11'b000_0000_0100,
        PH_EXT     = 11'b000_0000_1000,
        PH_CR      = 11'b000_0001_0000,
        PH_EXT_CR  = 11'b000_0010_0000,
        PH_DATA    = 11'b000_0100_0000,
        PH_DATA_CR = 11'b000_1000_0000,
        PH_DATA_LF = 11'b001_0000_0000,
        PH_TRAILER = 11'b010_0000_0000,
        PH_HALT    = 11'b100_0000_0000
    } t_phase;

    typedef enum logic [2:0] {
        K_DATA     = 3'd0,
        K_DONE     = 3'd1,
        K_BADSIZE  = 3'd2,
        K_TOOLARGE = 3'd3,
        K_MALFORM  = 3'd4
    } t_kind;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] data;
    } t_result;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) || (c == 8'h0C);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

endpackage

/* rtl/hcbd_fsm.sv */
// chunk parser state machine and counters, one byte per step
// depends on hcbd_pkg
module hcbd_fsm
    import hcbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_sob,
    input  logic [DATA_W-1:0] i_max_body,
    output t_result           o_result
);

    t_phase            r_phase, n_phase, cur_phase;
    logic [DATA_W-1:0] r_size, n_size, cur_size;
    logic              r_ovf, n_ovf, cur_ovf;
    logic [DATA_W-1:0] r_left, n_left, cur_left;
    logic [DATA_W-1:0] r_total, n_total, cur_total;
    logic [1:0]        r_tm, n_tm, cur_tm;

    logic              hex, ws;
    logic [DATA_W:0]   sum;
    logic [DATA_W-1:0] left_dec;
    t_phase            le_phase;
    logic              le_err;
    logic [1:0]        le_tm;
    t_result           res;

    always_comb begin
        cur_phase = i_sob ? PH_LEAD : r_phase;
        cur_size  = i_sob ? '0 : r_size;
        cur_ovf   = i_sob ? 1'b0 : r_ovf;
        cur_left  = i_sob ? '0 : r_left;
        cur_total = i_sob ? '0 : r_total;
        cur_tm    = i_sob ? 2'd0 : r_tm;
    end

    assign hex      = is_hex(i_byte);
    assign ws       = is_ws(i_byte);
    assign sum      = {1'b0, cur_total} + {1'b0, cur_size};
    assign left_dec = cur_left - DATA_W'(1);

    // end of size line
    always_comb begin
        le_err   = 1'b0;
        le_tm    = cur_tm;
        le_phase = PH_DATA;
        if (cur_ovf) begin
            le_err   = 1'b1;
            le_phase = PH_HALT;
        end else if (cur_size == '0) begin
            le_phase = PH_TRAILER;
            le_tm    = 2'd2;
        end else if (sum > {1'b0, i_max_body}) begin
            le_err   = 1'b1;
            le_phase = PH_HALT;
        end
    end

    always_comb begin
        n_phase = cur_phase;
        n_size  = cur_size;
        n_ovf   = cur_ovf;
        n_left  = cur_left;
        n_total = cur_total;
        n_tm    = cur_tm;
        res       = '0;
        res.kind  = K_DATA;
        unique case (cur_phase)
            PH_LEAD: begin
                if (hex) begin
                    n_ovf   = cur_ovf | (cur_size[DATA_W-1 -: 4] != 4'd0);
                    n_size  = {cur_size[DATA_W-5:0], hex_val(i_byte)};
                    n_phase = PH_DIGITS;
                end else if (!ws) begin
                    n_phase   = PH_HALT;
                    res.valid = 1'b1;
                    res.kind  = K_BADSIZE;
                end
            end
            PH_DIGITS, PH_TRAIL: begin
                if (hex && cur_phase == PH_DIGITS) begin
                    n_ovf  = cur_ovf | (cur_size[DATA_W-1 -: 4] != 4'd0);
                    n_size = {cur_size[DATA_W-5:0], hex_val(i_byte)};
                end else if (ws) begin
                    n_phase = PH_TRAIL;
                end else if (i_byte == CH_SEMI) begin
                    n_phase = PH_EXT;
                end else if (i_byte == CH_CR) begin
                    n_phase = PH_CR;
                end else begin
                    n_phase   = PH_HALT;
                    res.valid = 1'b1;
                    res.kind  = K_BADSIZE;
                end
            end
            PH_EXT: begin
                if (i_byte == CH_CR) begin
                    n_phase = PH_EXT_CR;
                end
            end
            PH_CR, PH_EXT_CR: begin
                if (i_byte == CH_LF) begin
                    n_phase   = le_phase;
                    n_tm      = le_tm;
                    n_left    = (le_phase == PH_DATA) ? cur_size : cur_left;
                    res.valid = le_err;
                    res.kind  = K_TOOLARGE;
                end else if (cur_phase == PH_CR) begin
                    n_phase   = PH_HALT;
                    res.valid = 1'b1;
                    res.kind  = K_BADSIZE;
                end else if (i_byte != CH_CR) begin
                    n_phase = PH_EXT;
                end
            end
            PH_DATA: begin
                res.valid = 1'b1;
                res.kind  = K_DATA;
                res.data  = i_byte;
                n_total   = cur_total + DATA_W'(1);
                n_left    = left_dec;
                if (left_dec == '0) begin
                    n_phase = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                if (i_byte == CH_CR) begin
                    n_phase = PH_DATA_LF;
                end else begin
                    n_phase   = PH_HALT;
                    res.valid = 1'b1;
                    res.kind  = K_MALFORM;
                end
            end
            PH_DATA_LF: begin
                if (i_byte == CH_LF) begin
                    n_size  = '0;
                    n_ovf   = 1'b0;
                    n_phase = PH_LEAD;
                end else begin
                    n_phase   = PH_HALT;
                    res.valid = 1'b1;
                    res.kind  = K_MALFORM;
                end
            end
            PH_TRAILER: begin
                if (i_byte == CH_CR) begin
                    n_tm = (cur_tm == 2'd2) ? 2'd3 : 2'd1;
                end else if (i_byte == CH_LF) begin
                    if (cur_tm == 2'd3) begin
                        n_phase   = PH_HALT;
                        res.valid = 1'b1;
                        res.kind  = K_DONE;
                    end else begin
                        n_tm = (cur_tm == 2'd1) ? 2'd2 : 2'd0;
                    end
                end else begin
                    n_tm = 2'd0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_size  <= '0;
            r_ovf   <= 1'b0;
            r_left  <= '0;
            r_total <= '0;
            r_tm    <= 2'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_size  <= n_size;
            r_ovf   <= n_ovf;
            r_left  <= n_left;
            r_total <= n_total;
            r_tm    <= n_tm;
        end
    end

endmodule

/* rtl/http_chunked_body_decoder.sv */
// top level of the chunked body decoder: input register, parser, result register
// and the limit register on the APB-style port; depends on hcbd_pkg and hcbd_fsm
//
// usage:
//   input channel: i_in_valid / o_in_ready carry one raw body byte per request,
//   with i_start_of_body set on the first byte of a new body
//   output channel: o_out_valid / i_out_ready carry one result per request,
//   o_kind 0 data byte, 1 body complete, 2 bad size, 3 too large, 4 malformed
//   config: max_body_bytes at byte address 0, written with psel/penable/pwrite
//   result path: a byte goes from the input register through the parser into the result register
//   throughput: one byte per cycle while results are taken; set by the parser step
//   between the input register and the result register
//   bytes that produce no result pass through without an output request
//   after done or an error, bytes give no result until the next start of body
//   reset: parser back to the size line, max_body_bytes to 64 MiB, both
//   registers empty
//   receiver stall: the result register holds, the input register fills and
//   then o_in_ready drops until the result is taken
module http_chunked_body_decoder
    import hcbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_in_byte,
    input  logic              i_start_of_body,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_kind,
    output logic [7:0]        o_out_byte,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_sob;
    logic              r_out_valid;
    t_kind             r_kind;
    logic [7:0]        r_out_byte;
    logic [DATA_W-1:0] r_max_body;
    logic              advance;
    logic              sel_max;
    t_result           res;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign pready  = 1'b1;
    assign sel_max = (paddr[ADDR_W-1:2] == ADDR_MAX_BODY[ADDR_W-1:2]);
    assign prdata  = sel_max ? r_max_body : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body <= MAX_BODY_RESET;
        end else if (psel && penable && pwrite && sel_max) begin
            r_max_body <= pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
            r_in_sob  <= i_start_of_body;
        end
    end

    hcbd_fsm u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_byte     (r_in_byte),
        .i_sob      (r_in_sob),
        .i_max_body (r_max_body),
        .o_result   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.valid) begin
            r_kind     <= res.kind;
            r_out_byte <= res.data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_out_byte  = r_out_byte;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a blocked result");

    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != K_DATA) |-> (o_out_byte == 8'h00))
        else $error("status result carries a nonzero byte");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_out_valid)) |-> $past(advance))
        else $error("result appeared without a parser step");

endmodule
